// ===== src/ffpa_pkg.sv =====
// Shared types and constants for the first-fit pool bump allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

  // Fixed field widths of the request and result transactions
  localparam int unsigned REQ_W     = 20;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned OFF_OUT_W = 15;

  // Command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_OUT_OF_POOLS = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// ===== src/ffpa_pool_mem.sv =====
// Pool table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ffpa_pool_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ffpa_fit_unit.sv =====
// Shared fit check and bump adder applied to one pool entry per cycle.
`timescale 1ns / 1ps

module ffpa_fit_unit #(
  parameter int unsigned POOL_BYTES = 16384,
  parameter int unsigned FILL_W     = 15
) (
  input  logic [ffpa_pkg::REQ_W-1:0] req,
  input  logic [FILL_W-1:0]          fill,
  input  logic                       oversized,
  output logic                       fits,
  output logic [FILL_W-1:0]          bumped
);

  logic [FILL_W-1:0] free_bytes;

  // Dedicated pools count as full, even for a zero-byte request
  assign free_bytes = FILL_W'(POOL_BYTES) - fill;
  assign fits       = !oversized && (req <= ffpa_pkg::REQ_W'(free_bytes));
  assign bumped     = fill + req[FILL_W-1:0];

endmodule

// ===== src/first_fit_pool_bump_allocator_top.sv =====
// Top level of the first-fit pool bump allocator.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Release-all, a
// request larger than POOL_BYTES, and any request while no pool is open
// are decided in the cycle in which they are taken. Any other allocation
// scans the open pools in order, one pool table read per cycle through the
// registered read port, checking each entry as its read returns.
// Each transaction yields exactly one result, shown on the out_ ports for
// one cycle with out_strobe high, in the cycle after the decision; the
// receiver cannot stall, so it must sample whenever out_strobe is high.
// Reset and release-all leave every pool unused; no clearing pass is needed
// since a pool entry is always written when its pool opens.
module first_fit_pool_bump_allocator_top #(
  parameter int unsigned POOL_BYTES = 16384,
  parameter int unsigned NUM_POOLS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [ffpa_pkg::REQ_W-1:0]         in_req_bytes,
  output logic                               out_strobe,
  output logic [ffpa_pkg::IDX_OUT_W-1:0]     out_pool_index,
  output logic [ffpa_pkg::OFF_OUT_W-1:0]     out_byte_offset,
  output logic                               out_dedicated,
  output logic                               out_status
);

  localparam int unsigned FILL_W = $clog2(POOL_BYTES + 1);
  localparam int unsigned IDX_W  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_POOLS + 1);
  localparam int unsigned MEM_W  = FILL_W + 1;

  ffpa_pkg::state_t state_r, state_nxt;

  logic [ffpa_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]           pools_open_r, pools_open_nxt;
  logic [CNT_W-1:0]           scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]           chk_idx_r, chk_idx_nxt;
  logic                       chk_vld_r, chk_vld_nxt;

  logic                           out_strobe_r;
  logic [ffpa_pkg::IDX_OUT_W-1:0] out_pool_index_r;
  logic [ffpa_pkg::OFF_OUT_W-1:0] out_byte_offset_r;
  logic                           out_dedicated_r;
  logic                           out_status_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [MEM_W-1:0]  mem_rdata;

  logic [FILL_W-1:0] rd_fill;
  logic              rd_oversized;
  logic              fits;
  logic [FILL_W-1:0] bumped;

  logic              res_vld;
  logic [CNT_W-1:0]  res_idx;
  logic [FILL_W-1:0] res_off;
  logic              res_ded;
  logic              res_status;
  logic [31:0]       res_idx_ext;
  logic [31:0]       res_off_ext;

  logic accept;
  logic all_open;
  logic big_req;
  logic last_chk;

  ffpa_pool_mem #(
    .DEPTH  (NUM_POOLS),
    .ADDR_W (IDX_W),
    .DATA_W (MEM_W)
  ) u_pool_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_fill      = mem_rdata[FILL_W-1:0];
  assign rd_oversized = mem_rdata[FILL_W];

  ffpa_fit_unit #(
    .POOL_BYTES (POOL_BYTES),
    .FILL_W     (FILL_W)
  ) u_fit_unit (
    .req       (req_r),
    .fill      (rd_fill),
    .oversized (rd_oversized),
    .fits      (fits),
    .bumped    (bumped)
  );

  assign busy     = (state_r != ffpa_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign all_open = (pools_open_r == CNT_W'(NUM_POOLS));
  assign big_req  = (in_req_bytes > ffpa_pkg::REQ_W'(POOL_BYTES));
  assign last_chk = (CNT_W'(chk_idx_r + 1'b1) == pools_open_r);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    pools_open_nxt = pools_open_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    mem_we         = 1'b0;
    mem_waddr      = pools_open_r[IDX_W-1:0];
    mem_wdata      = '0;
    mem_raddr      = scan_idx_r[IDX_W-1:0];
    res_vld        = 1'b0;
    res_idx        = '0;
    res_off        = '0;
    res_ded        = 1'b0;
    res_status     = ffpa_pkg::STATUS_OK;

    case (state_r)
      ffpa_pkg::ST_IDLE: begin
        if (accept) begin
          res_vld = 1'b1;
          if (in_cmd == ffpa_pkg::CMD_RELEASE) begin
            pools_open_nxt = '0;
          end else if (big_req) begin
            if (all_open) begin
              res_status = ffpa_pkg::STATUS_OUT_OF_POOLS;
            end else begin
              // Open a dedicated pool and mark it full
              mem_we         = 1'b1;
              mem_wdata      = {1'b1, FILL_W'(POOL_BYTES)};
              pools_open_nxt = CNT_W'(pools_open_r + 1'b1);
              res_idx        = pools_open_r;
              res_ded        = 1'b1;
            end
          end else if (pools_open_r == '0) begin
            mem_we         = 1'b1;
            mem_wdata      = {1'b0, in_req_bytes[FILL_W-1:0]};
            pools_open_nxt = CNT_W'(1);
          end else begin
            res_vld      = 1'b0;
            req_nxt      = in_req_bytes;
            scan_idx_nxt = '0;
            chk_vld_nxt  = 1'b0;
            state_nxt    = ffpa_pkg::ST_SCAN;
          end
        end
      end

      ffpa_pkg::ST_SCAN: begin
        // Issue the next read while checking the entry read last cycle
        scan_idx_nxt = CNT_W'(scan_idx_r + 1'b1);
        chk_idx_nxt  = scan_idx_r;
        chk_vld_nxt  = (scan_idx_r < pools_open_r);
        if (chk_vld_r) begin
          if (fits) begin
            mem_we    = 1'b1;
            mem_waddr = chk_idx_r[IDX_W-1:0];
            mem_wdata = {1'b0, bumped};
            res_vld   = 1'b1;
            res_idx   = chk_idx_r;
            res_off   = rd_fill;
            state_nxt = ffpa_pkg::ST_IDLE;
          end else if (last_chk) begin
            res_vld   = 1'b1;
            state_nxt = ffpa_pkg::ST_IDLE;
            if (all_open) begin
              res_status = ffpa_pkg::STATUS_OUT_OF_POOLS;
            end else begin
              mem_we         = 1'b1;
              mem_wdata      = {1'b0, req_r[FILL_W-1:0]};
              pools_open_nxt = CNT_W'(pools_open_r + 1'b1);
              res_idx        = pools_open_r;
            end
          end
        end
      end

      default: begin
        state_nxt = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_idx_ext = 32'(res_idx);
  assign res_off_ext = 32'(res_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffpa_pkg::ST_IDLE;
      pools_open_r <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pools_open_r <= pools_open_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_strobe_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    if (res_vld) begin
      out_pool_index_r  <= res_idx_ext[ffpa_pkg::IDX_OUT_W-1:0];
      out_byte_offset_r <= res_off_ext[ffpa_pkg::OFF_OUT_W-1:0];
      out_dedicated_r   <= res_ded;
      out_status_r      <= res_status;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_pool_index  = out_pool_index_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_dedicated   = out_dedicated_r;
  assign out_status      = out_status_r;

endmodule
